// File: design/ltqp_pkg.sv
`default_nettype none

package ltqp_pkg;

    // Default likelihood width and fixed packing geometry
    localparam int LIKELIHOOD_BITS_DEF = 16;
    localparam int TRIOS_PER_WORD      = 4;
    localparam int CODE_BITS           = 4;
    localparam int BYTE_BITS           = 2 * CODE_BITS;
    localparam int WORD_BITS           = TRIOS_PER_WORD * BYTE_BITS;
    localparam int PART_BITS           = WORD_BITS - BYTE_BITS;
    localparam int TRIO_CNT_W          = $clog2(TRIOS_PER_WORD);
    localparam int STEP_CNT_W          = $clog2(CODE_BITS);

    localparam logic [TRIO_CNT_W-1:0] LAST_TRIO = TRIO_CNT_W'(TRIOS_PER_WORD - 1);
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(CODE_BITS - 1);

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PACK = 3'b100
    } t_state;

    // Control toward the serial dividers
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    // One finished code byte toward the packer
    typedef struct packed {
        logic                 push;
        logic                 zero_sum;
        logic [BYTE_BITS-1:0] code_byte;
    } t_pack_req;

endpackage

`default_nettype wire

// File: design/likelihood_trio_quantize_pack_core.sv
`default_nettype none

// Channel  Dir  Handshake                 Payload
// input    in   i_in_valid / o_in_stall   i_gl_rr, i_gl_het, i_gl_hom
// output   out  o_out_valid / i_out_stall o_packed_word, o_zero_sum_seen
//
// Each trio passes through the accept cycle, the shared-sum serial dividers
// (one quotient bit per cycle, RR and Het side by side), and a push of the
// code byte into the packer once the packer can take it.
// A word leaves on every fourth trio through a registered output stage.
// Reset is synchronous, active low, and clears the sequencer and packer.
// A stalled output only holds the core when the fourth byte is ready and
// the previous word has not been taken yet.
module likelihood_trio_quantize_pack_core #(
    parameter int LIKELIHOOD_BITS = ltqp_pkg::LIKELIHOOD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [LIKELIHOOD_BITS-1:0]     i_gl_rr,
    input  wire logic [LIKELIHOOD_BITS-1:0]     i_gl_het,
    input  wire logic [LIKELIHOOD_BITS-1:0]     i_gl_hom,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [ltqp_pkg::WORD_BITS-1:0] o_packed_word,
    output logic                                o_zero_sum_seen
);

    localparam int SUM_W = LIKELIHOOD_BITS + 2;

    ltqp_pkg::t_state                r_state;
    ltqp_pkg::t_state                n_state;
    logic [ltqp_pkg::STEP_CNT_W-1:0] r_step;
    logic [ltqp_pkg::STEP_CNT_W-1:0] n_step;
    logic [SUM_W-1:0]                r_sum;
    logic [SUM_W-1:0]                n_sum;
    logic                            r_sum_zero;
    logic                            n_sum_zero;
    logic [SUM_W-1:0]                w_sum;
    logic                            w_accept;
    logic                            w_pack_ready;
    logic [ltqp_pkg::CODE_BITS-1:0]  w_code_rr;
    logic [ltqp_pkg::CODE_BITS-1:0]  w_code_het;
    ltqp_pkg::t_div_ctrl             w_div_ctrl;
    ltqp_pkg::t_pack_req             w_pack_req;

    // Take a trio only when the sequencer is free
    assign o_in_stall = (r_state != ltqp_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Full trio sum, two guard bits so it never wraps
    assign w_sum = {2'b00, i_gl_rr} + {2'b00, i_gl_het} + {2'b00, i_gl_hom};

    // Load the dividers straight from the inputs on accept, then step them
    assign w_div_ctrl.load = w_accept;
    assign w_div_ctrl.step = (r_state == ltqp_pkg::S_DIV);

    // Drop both codes to zero when the whole trio is zero
    assign w_pack_req.push      = (r_state == ltqp_pkg::S_PACK) && w_pack_ready;
    assign w_pack_req.zero_sum  = r_sum_zero;
    assign w_pack_req.code_byte = r_sum_zero ? '0 : {w_code_rr, w_code_het};

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_sum      = r_sum;
        n_sum_zero = r_sum_zero;
        unique case (r_state)
            ltqp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_sum      = w_sum;
                    n_sum_zero = (w_sum == '0);
                    n_step     = '0;
                    n_state    = ltqp_pkg::S_DIV;
                end
            end
            ltqp_pkg::S_DIV: begin
                // advance one quotient bit per cycle
                n_step = r_step + 1'b1;
                if (r_step == ltqp_pkg::LAST_STEP) begin
                    n_state = ltqp_pkg::S_PACK;
                end
            end
            ltqp_pkg::S_PACK: begin
                // hold until the packer can take the byte
                if (w_pack_ready) begin
                    n_state = ltqp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ltqp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltqp_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_sum      <= n_sum;
        r_sum_zero <= n_sum_zero;
    end

    ltqp_serdiv #(
        .VAL_W (LIKELIHOOD_BITS),
        .SUM_W (SUM_W)
    ) u_div_rr (
        .i_clk   (i_clk),
        .i_ctrl  (w_div_ctrl),
        .i_value (i_gl_rr),
        .i_sum   (r_sum),
        .o_code  (w_code_rr)
    );

    ltqp_serdiv #(
        .VAL_W (LIKELIHOOD_BITS),
        .SUM_W (SUM_W)
    ) u_div_het (
        .i_clk   (i_clk),
        .i_ctrl  (w_div_ctrl),
        .i_value (i_gl_het),
        .i_sum   (r_sum),
        .o_code  (w_code_het)
    );

    ltqp_packer u_packer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (w_pack_req),
        .o_ready         (w_pack_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_packed_word   (o_packed_word),
        .o_zero_sum_seen (o_zero_sum_seen)
    );

`ifndef SYNTHESIS
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ltqp_pkg::S_DIV))
        else $error("accepted transaction did not start division");

    a_word_after_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ltqp_pkg::S_PACK))
        else $error("output word appeared without a packed byte");

    a_pack_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ltqp_pkg::S_PACK) && !w_pack_ready) |=>
        (r_state == ltqp_pkg::S_PACK))
        else $error("code byte lost while packer was full");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ltqp_pkg::S_PACK) |->
        ($past(r_state == ltqp_pkg::S_DIV) || $past(r_state == ltqp_pkg::S_PACK)))
        else $error("pack entered without division");
`endif

endmodule

`default_nettype wire

// File: design/ltqp_serdiv.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// code = floor((16*v - 1) / s) for v > 0, else 0.
module ltqp_serdiv #(
    parameter int VAL_W = ltqp_pkg::LIKELIHOOD_BITS_DEF,
    parameter int SUM_W = VAL_W + 2
) (
    input  wire logic                           i_clk,
    input  wire ltqp_pkg::t_div_ctrl            i_ctrl,
    input  wire logic [VAL_W-1:0]               i_value,
    input  wire logic [SUM_W-1:0]               i_sum,
    output logic      [ltqp_pkg::CODE_BITS-1:0] o_code
);

    logic [SUM_W-1:0]               r_rem;
    logic [SUM_W-1:0]               n_rem;
    logic [ltqp_pkg::CODE_BITS-1:0] r_quo;
    logic [ltqp_pkg::CODE_BITS-1:0] n_quo;
    logic                           r_val_zero;
    logic                           n_val_zero;
    logic [SUM_W:0]                 w_trial;
    logic [SUM_W:0]                 w_diff;
    logic                           w_fits;

    // Shift in the next numerator bit; the low nibble of 16*v-1 is all ones
    assign w_trial = {r_rem, 1'b1};
    assign w_diff  = w_trial - {1'b0, i_sum};
    assign w_fits  = (w_trial >= {1'b0, i_sum});

    always_comb begin
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_val_zero = r_val_zero;
        if (i_ctrl.load) begin
            n_val_zero = (i_value == '0);
            n_rem      = (i_value == '0) ? '0 : ({{(SUM_W-VAL_W){1'b0}}, i_value} - SUM_W'(1));
            n_quo      = '0;
        end else if (i_ctrl.step) begin
            n_rem = w_fits ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
            n_quo = {r_quo[ltqp_pkg::CODE_BITS-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_val_zero <= n_val_zero;
    end

    assign o_code = r_val_zero ? '0 : r_quo;

endmodule

`default_nettype wire

// File: design/ltqp_packer.sv
`default_nettype none

// Gather code bytes into a word; hold the finished word for the output side.
module ltqp_packer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ltqp_pkg::t_pack_req            i_req,
    output logic                                o_ready,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [ltqp_pkg::WORD_BITS-1:0] o_packed_word,
    output logic                                o_zero_sum_seen
);

    logic [ltqp_pkg::TRIO_CNT_W-1:0] r_cnt;
    logic [ltqp_pkg::TRIO_CNT_W-1:0] n_cnt;
    logic [ltqp_pkg::PART_BITS-1:0]  r_part;
    logic [ltqp_pkg::PART_BITS-1:0]  n_part;
    logic                            r_err;
    logic                            n_err;
    logic [ltqp_pkg::WORD_BITS-1:0]  r_word;
    logic [ltqp_pkg::WORD_BITS-1:0]  n_word;
    logic                            r_flag;
    logic                            n_flag;
    logic                            r_valid;
    logic                            n_valid;
    logic                            w_last;

    assign w_last  = (r_cnt == ltqp_pkg::LAST_TRIO);
    assign o_ready = !w_last || !r_valid || !i_out_stall;

    always_comb begin
        n_cnt   = r_cnt;
        n_part  = r_part;
        n_err   = r_err;
        n_word  = r_word;
        n_flag  = r_flag;
        n_valid = r_valid && i_out_stall;
        if (i_req.push) begin
            if (w_last) begin
                n_word  = {r_part, i_req.code_byte};
                n_flag  = r_err || i_req.zero_sum;
                n_valid = 1'b1;
                n_cnt   = '0;
                n_part  = '0;
                n_err   = 1'b0;
            end else begin
                n_part = {r_part[ltqp_pkg::PART_BITS-ltqp_pkg::BYTE_BITS-1:0],
                          i_req.code_byte};
                n_err  = r_err || i_req.zero_sum;
                n_cnt  = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_part  <= '0;
            r_err   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_part  <= n_part;
            r_err   <= n_err;
            r_valid <= n_valid;
        end
        r_word <= n_word;
        r_flag <= n_flag;
    end

    assign o_out_valid     = r_valid;
    assign o_packed_word   = r_word;
    assign o_zero_sum_seen = r_flag;

endmodule

`default_nettype wire
